@@ rtl/dlq_pkg.sv @@
// Types, codes and the control store of the doubly linked queue manager.
// Shared by dlq_seq and doubly_linked_queue_manager; depends on nothing.

package dlq_pkg;

	// Request and result transfers
	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] queue_id;
		logic [5:0] node;
		logic [5:0] ref_node;
	} req_t;

	typedef struct packed {
		logic [5:0] popped_node;
		logic       popped_valid;
		logic       queue_nonempty;
	} rsp_t;

	// Operation codes carried in req_t.mode
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_INSERT     = 3'd2;
	localparam logic [2:0] MODE_POP        = 3'd3;
	localparam logic [2:0] MODE_UNLINK     = 3'd4;

	// Control store addresses
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_RD  = 5'd0;
	localparam step_t S_LAT = 5'd1;
	localparam step_t S_FIN = 5'd2;
	localparam step_t S_PF0 = 5'd3;
	localparam step_t S_PF1 = 5'd4;
	localparam step_t S_PFE = 5'd5;
	localparam step_t S_PB0 = 5'd6;
	localparam step_t S_PB1 = 5'd7;
	localparam step_t S_PBE = 5'd8;
	localparam step_t S_IN0 = 5'd9;
	localparam step_t S_IN1 = 5'd10;
	localparam step_t S_IN2 = 5'd11;
	localparam step_t S_IN3 = 5'd12;
	localparam step_t S_PO0 = 5'd13;
	localparam step_t S_PO1 = 5'd14;
	localparam step_t S_PO2 = 5'd15;
	localparam step_t S_POE = 5'd16;
	localparam step_t S_UN0 = 5'd17;
	localparam step_t S_UN1 = 5'd18;
	localparam step_t S_UNH = 5'd19;
	localparam step_t S_UNT = 5'd20;

	// Operand sources for link addresses and data
	typedef enum logic [2:0] {
		SRC_NIL = 3'd0,
		SRC_N   = 3'd1,
		SRC_R   = 3'd2,
		SRC_H   = 3'd3,
		SRC_T   = 3'd4,
		SRC_P   = 3'd5,
		SRC_X   = 3'd6
	} src_t;

	typedef enum logic [1:0] {
		J_NEXT     = 2'd0,
		J_GOTO     = 2'd1,
		J_DISPATCH = 2'd2,
		J_COND     = 2'd3
	} jmp_t;

	typedef enum logic [2:0] {
		C_H_NIL  = 3'd0,
		C_T_NIL  = 3'd1,
		C_P_NIL  = 3'd2,
		C_X_NIL  = 3'd3,
		C_PV_NIL = 3'd4,
		C_NX_NIL = 3'd5
	} cond_t;

	// One control word; fin ends the item unless a conditional jump is taken
	typedef struct packed {
		src_t  nx_ra;
		src_t  pv_ra;
		logic  nx_we;
		src_t  nx_wa;
		src_t  nx_wd;
		logic  pv_we;
		src_t  pv_wa;
		src_t  pv_wd;
		logic  hd_we;
		src_t  hd_wd;
		logic  tl_we;
		src_t  tl_wd;
		logic  ld_ht;
		logic  ld_p;
		logic  ld_x;
		logic  set_pop;
		logic  fin;
		jmp_t  jmp;
		cond_t cnd;
		step_t target;
	} ctl_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic       h_nil;
		logic       t_nil;
		logic       p_nil;
		logic       x_nil;
		logic       pv_nil;
		logic       nx_nil;
		logic       op_ok;
		logic [2:0] mode;
	} dp_stat_t;

	// Sequencer status seen by the datapath
	typedef struct packed {
		logic busy;
		logic exec;
		logic done;
	} seq_stat_t;

	// Entry point of each operation
	function automatic step_t entry_step(input logic [2:0] mode, input logic ok);
		step_t s;
		s = S_FIN;
		if (ok) begin
			unique case (mode)
				MODE_PUSH_FRONT: s = S_PF0;
				MODE_PUSH_BACK:  s = S_PB0;
				MODE_INSERT:     s = S_IN0;
				MODE_POP:        s = S_PO0;
				MODE_UNLINK:     s = S_UN0;
				default:         s = S_FIN;
			endcase
		end
		return s;
	endfunction

	// Control store
	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		w = '0;
		unique case (s)
			S_RD: begin
				w.nx_ra = SRC_N;
				w.pv_ra = SRC_N;
			end
			S_LAT: begin
				w.ld_ht = 1'b1;
				w.ld_p  = 1'b1;
				w.ld_x  = 1'b1;
				w.jmp   = J_DISPATCH;
			end
			S_FIN: begin
				w.fin = 1'b1;
			end
			// push front: next[n]=h, prev[h]=n, then prev[n]=nil, head=n (and tail=n if empty)
			S_PF0: begin
				w.nx_we  = 1'b1;
				w.nx_wa  = SRC_N;
				w.nx_wd  = SRC_H;
				w.pv_we  = 1'b1;
				w.pv_wa  = SRC_H;
				w.pv_wd  = SRC_N;
				w.jmp    = J_COND;
				w.cnd    = C_H_NIL;
				w.target = S_PFE;
			end
			S_PF1: begin
				w.pv_we = 1'b1;
				w.pv_wa = SRC_N;
				w.pv_wd = SRC_NIL;
				w.hd_we = 1'b1;
				w.hd_wd = SRC_N;
				w.fin   = 1'b1;
			end
			S_PFE: begin
				w.pv_we = 1'b1;
				w.pv_wa = SRC_N;
				w.pv_wd = SRC_NIL;
				w.hd_we = 1'b1;
				w.hd_wd = SRC_N;
				w.tl_we = 1'b1;
				w.tl_wd = SRC_N;
				w.fin   = 1'b1;
			end
			// push back: next[t]=n, prev[n]=t, then next[n]=nil, tail=n (and head=n if empty)
			S_PB0: begin
				w.nx_we  = 1'b1;
				w.nx_wa  = SRC_T;
				w.nx_wd  = SRC_N;
				w.pv_we  = 1'b1;
				w.pv_wa  = SRC_N;
				w.pv_wd  = SRC_T;
				w.jmp    = J_COND;
				w.cnd    = C_T_NIL;
				w.target = S_PBE;
			end
			S_PB1: begin
				w.nx_we = 1'b1;
				w.nx_wa = SRC_N;
				w.nx_wd = SRC_NIL;
				w.tl_we = 1'b1;
				w.tl_wd = SRC_N;
				w.fin   = 1'b1;
			end
			S_PBE: begin
				w.nx_we = 1'b1;
				w.nx_wa = SRC_N;
				w.nx_wd = SRC_NIL;
				w.tl_we = 1'b1;
				w.tl_wd = SRC_N;
				w.hd_we = 1'b1;
				w.hd_wd = SRC_N;
				w.fin   = 1'b1;
			end
			// insert before r; a ref with no predecessor falls back to push front
			S_IN0: begin
				w.pv_ra = SRC_R;
			end
			S_IN1: begin
				w.ld_p   = 1'b1;
				w.jmp    = J_COND;
				w.cnd    = C_PV_NIL;
				w.target = S_PF0;
			end
			S_IN2: begin
				w.nx_we = 1'b1;
				w.nx_wa = SRC_P;
				w.nx_wd = SRC_N;
				w.pv_we = 1'b1;
				w.pv_wa = SRC_N;
				w.pv_wd = SRC_P;
			end
			S_IN3: begin
				w.pv_we = 1'b1;
				w.pv_wa = SRC_R;
				w.pv_wd = SRC_N;
				w.nx_we = 1'b1;
				w.nx_wa = SRC_N;
				w.nx_wd = SRC_R;
				w.fin   = 1'b1;
			end
			// pop front
			S_PO0: begin
				w.nx_ra  = SRC_H;
				w.jmp    = J_COND;
				w.cnd    = C_H_NIL;
				w.target = S_FIN;
			end
			S_PO1: begin
				w.set_pop = 1'b1;
				w.ld_x    = 1'b1;
				w.jmp     = J_COND;
				w.cnd     = C_NX_NIL;
				w.target  = S_POE;
			end
			S_PO2: begin
				w.hd_we = 1'b1;
				w.hd_wd = SRC_X;
				w.pv_we = 1'b1;
				w.pv_wa = SRC_X;
				w.pv_wd = SRC_NIL;
				w.fin   = 1'b1;
			end
			S_POE: begin
				w.hd_we = 1'b1;
				w.hd_wd = SRC_NIL;
				w.tl_we = 1'b1;
				w.tl_wd = SRC_NIL;
				w.fin   = 1'b1;
			end
			// unlink n: p and x were latched from prev[n] and next[n]
			S_UN0: begin
				w.nx_we  = 1'b1;
				w.nx_wa  = SRC_P;
				w.nx_wd  = SRC_X;
				w.jmp    = J_COND;
				w.cnd    = C_P_NIL;
				w.target = S_UNH;
			end
			S_UN1: begin
				w.pv_we  = 1'b1;
				w.pv_wa  = SRC_X;
				w.pv_wd  = SRC_P;
				w.jmp    = J_COND;
				w.cnd    = C_X_NIL;
				w.target = S_UNT;
				w.fin    = 1'b1;
			end
			S_UNH: begin
				w.hd_we  = 1'b1;
				w.hd_wd  = SRC_X;
				w.jmp    = J_GOTO;
				w.target = S_UN1;
			end
			S_UNT: begin
				w.tl_we = 1'b1;
				w.tl_wd = SRC_P;
				w.fin   = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

@@ rtl/doubly_linked_queue_manager.sv @@
// Top level of the doubly linked queue manager: link and head/tail memories,
// operand registers and result register. Depends on dlq_pkg and dlq_seq.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   dlq_pkg::req_t (mode, queue_id, node, ref_node)
//  rsp      out        rsp_valid/rsp_stall   dlq_pkg::rsp_t (popped_node, popped_valid,
//                                            queue_nonempty)
//
// An operation runs as microcode steps, one memory access per port a step; a
// rejected request runs only the read, latch and finish steps. The next request
// transfers in the cycle the last step runs. Reset clears the per-queue head/tail
// valid bits so every queue starts empty; the link memories are not cleared. A held
// result stalls only the final step.

module doubly_linked_queue_manager #(
	parameter int NODES  = 64,
	parameter int QUEUES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dlq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dlq_pkg::rsp_t  rsp
);

	localparam int LW = $clog2(NODES + 1);
	localparam int IW = $clog2(NODES);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [LW-1:0] NIL = LW'(NODES);

	function automatic logic is_nil(input logic [LW-1:0] v);
		return v >= NIL;
	endfunction

	// Operand select: v holds {x, p, t, h, r, n}
	function automatic logic [LW-1:0] pick(input dlq_pkg::src_t s, input logic [6*LW-1:0] v);
		logic [LW-1:0] r;
		unique case (s)
			dlq_pkg::SRC_N: r = v[0*LW +: LW];
			dlq_pkg::SRC_R: r = v[1*LW +: LW];
			dlq_pkg::SRC_H: r = v[2*LW +: LW];
			dlq_pkg::SRC_T: r = v[3*LW +: LW];
			dlq_pkg::SRC_P: r = v[4*LW +: LW];
			dlq_pkg::SRC_X: r = v[5*LW +: LW];
			default:        r = NIL;
		endcase
		return r;
	endfunction

	dlq_pkg::ctl_t      ctl;
	dlq_pkg::seq_stat_t sst;
	dlq_pkg::dp_stat_t  stat;

	logic          start;
	logic          n_ok, r_ok, q_ok;
	logic [2:0]    mode_q;
	logic [QW-1:0] q_q;
	logic [LW-1:0] n_q, r_q, h_q, t_q, p_q, x_q;
	logic          q_ok_q, ok_q;
	logic [LW-1:0] pop_n_q;
	logic          pop_v_q;
	logic [6*LW-1:0] opnd;

	// Link and head/tail memories with their read registers
	logic [LW-1:0] next_mem [NODES];
	logic [LW-1:0] prev_mem [NODES];
	logic [LW-1:0] head_mem [QUEUES];
	logic [LW-1:0] tail_mem [QUEUES];
	logic [LW-1:0] nx_rd_q, pv_rd_q, head_rd_q, tail_rd_q;
	logic          nx_rnil_q, pv_rnil_q;
	logic [QUEUES-1:0] hv_q, tv_q;
	logic          hv_rd_q, tv_rd_q;

	logic [LW-1:0] nx_eff, pv_eff, hd_eff, tl_eff;
	logic [LW-1:0] nx_ra_v, pv_ra_v, nx_wa_v, nx_wd_v, pv_wa_v, pv_wd_v, hd_wd_v, tl_wd_v;
	logic          nx_wr, pv_wr, hd_wr, tl_wr;
	logic [LW-1:0] h_d;

	logic          rsp_valid_q;
	dlq_pkg::rsp_t rsp_q;

	// Request side
	assign start     = req_valid && !req_stall;
	assign req_stall = sst.busy && !sst.done;

	assign q_ok = 32'(req.queue_id) < 32'(QUEUES);
	assign n_ok = 32'(req.node) < 32'(NODES);
	assign r_ok = 32'(req.ref_node) < 32'(NODES);

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= req.mode;
			q_q    <= QW'(req.queue_id);
			n_q    <= n_ok ? LW'(req.node) : NIL;
			r_q    <= r_ok ? LW'(req.ref_node) : NIL;
			q_ok_q <= q_ok;
			ok_q   <= q_ok && ((req.mode == dlq_pkg::MODE_POP) ||
				(n_ok && ((req.mode != dlq_pkg::MODE_INSERT) || r_ok)));
		end
	end

	// Sequencer
	dlq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.out_block (rsp_valid_q && rsp_stall),
		.stat      (stat),
		.ctl       (ctl),
		.sst       (sst)
	);

	// Operand routing
	assign opnd    = {x_q, p_q, t_q, h_q, r_q, n_q};
	assign nx_ra_v = pick(ctl.nx_ra, opnd);
	assign pv_ra_v = pick(ctl.pv_ra, opnd);
	assign nx_wa_v = pick(ctl.nx_wa, opnd);
	assign nx_wd_v = pick(ctl.nx_wd, opnd);
	assign pv_wa_v = pick(ctl.pv_wa, opnd);
	assign pv_wd_v = pick(ctl.pv_wd, opnd);
	assign hd_wd_v = pick(ctl.hd_wd, opnd);
	assign tl_wd_v = pick(ctl.tl_wd, opnd);

	// A link write at the null code is dropped
	assign nx_wr = sst.exec && ctl.nx_we && !is_nil(nx_wa_v);
	assign pv_wr = sst.exec && ctl.pv_we && !is_nil(pv_wa_v);
	assign hd_wr = sst.exec && ctl.hd_we;
	assign tl_wr = sst.exec && ctl.tl_we;

	always_ff @(posedge clk) begin
		if (nx_wr) begin
			next_mem[nx_wa_v[IW-1:0]] <= nx_wd_v;
		end
		nx_rd_q <= next_mem[nx_ra_v[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pv_wr) begin
			prev_mem[pv_wa_v[IW-1:0]] <= pv_wd_v;
		end
		pv_rd_q <= prev_mem[pv_ra_v[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hd_wr) begin
			head_mem[q_q] <= hd_wd_v;
		end
		head_rd_q <= head_mem[q_q];
	end

	always_ff @(posedge clk) begin
		if (tl_wr) begin
			tail_mem[q_q] <= tl_wd_v;
		end
		tail_rd_q <= tail_mem[q_q];
	end

	// Head/tail valid bits and read-side null flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q      <= '0;
			tv_q      <= '0;
			hv_rd_q   <= 1'b0;
			tv_rd_q   <= 1'b0;
			nx_rnil_q <= 1'b1;
			pv_rnil_q <= 1'b1;
		end else begin
			if (hd_wr) begin
				hv_q[q_q] <= 1'b1;
			end
			if (tl_wr) begin
				tv_q[q_q] <= 1'b1;
			end
			hv_rd_q   <= hv_q[q_q];
			tv_rd_q   <= tv_q[q_q];
			nx_rnil_q <= is_nil(nx_ra_v);
			pv_rnil_q <= is_nil(pv_ra_v);
		end
	end

	assign nx_eff = nx_rnil_q ? NIL : nx_rd_q;
	assign pv_eff = pv_rnil_q ? NIL : pv_rd_q;
	assign hd_eff = hv_rd_q ? head_rd_q : NIL;
	assign tl_eff = tv_rd_q ? tail_rd_q : NIL;

	// Working registers; h_q shadows every head write
	always_ff @(posedge clk) begin
		if (sst.exec) begin
			if (ctl.ld_ht) begin
				h_q <= hd_eff;
				t_q <= tl_eff;
			end else if (ctl.hd_we) begin
				h_q <= hd_wd_v;
			end
			if (ctl.ld_p) begin
				p_q <= pv_eff;
			end
			if (ctl.ld_x) begin
				x_q <= nx_eff;
			end
			if (ctl.set_pop) begin
				pop_n_q <= h_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_v_q <= 1'b0;
		end else if (start) begin
			pop_v_q <= 1'b0;
		end else if (sst.exec && ctl.set_pop) begin
			pop_v_q <= 1'b1;
		end
	end

	// Flags for the sequencer
	assign stat.h_nil  = is_nil(h_q);
	assign stat.t_nil  = is_nil(t_q);
	assign stat.p_nil  = is_nil(p_q);
	assign stat.x_nil  = is_nil(x_q);
	assign stat.pv_nil = is_nil(pv_eff);
	assign stat.nx_nil = is_nil(nx_eff);
	assign stat.op_ok  = ok_q;
	assign stat.mode   = mode_q;

	// Result register; head after the final step decides non-empty
	assign h_d = ctl.hd_we ? hd_wd_v : h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (sst.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sst.done) begin
			rsp_q.popped_node    <= pop_v_q ? 6'(pop_n_q) : 6'd0;
			rsp_q.popped_valid   <= pop_v_q;
			rsp_q.queue_nonempty <= q_ok_q && !is_nil(h_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> sst.busy)
		else $error("sequencer not busy after a request transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sst.done |-> !(rsp_valid_q && rsp_stall))
		else $error("finishing step while the result register is held");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(sst.done && pop_v_q) |-> (mode_q == dlq_pkg::MODE_POP))
		else $error("popped node reported for an operation other than pop");

	a_queue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(hd_wr || tl_wr) |-> q_ok_q)
		else $error("head or tail written for a queue out of range");
`endif

endmodule

@@ rtl/dlq_seq.sv @@
// Microcode sequencer of the queue manager: step counter, control store
// lookup and jump logic. Depends on dlq_pkg.

module dlq_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 out_block,
	input  dlq_pkg::dp_stat_t    stat,
	output dlq_pkg::ctl_t        ctl,
	output dlq_pkg::seq_stat_t   sst
);

	logic           busy_q;
	dlq_pkg::step_t step_q;
	dlq_pkg::step_t step_nxt;
	logic           cond_hit;
	logic           take;
	logic           fin_eff;
	logic           exec;

	// Control word for the current step
	assign ctl = dlq_pkg::ucode(step_q);

	// Condition select and next step
	always_comb begin
		unique case (ctl.cnd)
			dlq_pkg::C_H_NIL:  cond_hit = stat.h_nil;
			dlq_pkg::C_T_NIL:  cond_hit = stat.t_nil;
			dlq_pkg::C_P_NIL:  cond_hit = stat.p_nil;
			dlq_pkg::C_X_NIL:  cond_hit = stat.x_nil;
			dlq_pkg::C_PV_NIL: cond_hit = stat.pv_nil;
			dlq_pkg::C_NX_NIL: cond_hit = stat.nx_nil;
			default:           cond_hit = 1'b0;
		endcase
		take = (ctl.jmp == dlq_pkg::J_COND) && cond_hit;
		unique case (ctl.jmp)
			dlq_pkg::J_NEXT:     step_nxt = step_q + 1'b1;
			dlq_pkg::J_GOTO:     step_nxt = ctl.target;
			dlq_pkg::J_DISPATCH: step_nxt = dlq_pkg::entry_step(stat.mode, stat.op_ok);
			dlq_pkg::J_COND:     step_nxt = take ? ctl.target : step_q + 1'b1;
		endcase
	end

	// A finishing step waits while the result register is still held
	assign fin_eff = ctl.fin && !take;
	assign exec    = busy_q && !(fin_eff && out_block);

	assign sst.busy = busy_q;
	assign sst.exec = exec;
	assign sst.done = exec && fin_eff;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= dlq_pkg::S_RD;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= dlq_pkg::S_RD;
		end else if (exec) begin
			if (fin_eff) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_nxt;
			end
		end
	end

endmodule
